FILE: rtl/nta_pkg.sv
// Shared types, constants and opcodes of the NTP timestamp arithmetic unit.
package nta_pkg;

   localparam int STAMP_W   = 64;
   localparam int WORD_W    = 32;
   localparam int NANOS_W   = 30;
   localparam int MICROS_W  = 20;

   // one quotient bit per divider stage
   localparam int DIV_STAGES = STAMP_W;
   // front stage + divider + six back stages
   localparam int LATENCY    = DIV_STAGES + 7;

   localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
   localparam logic [31:0] NS_PER_SEC     = 32'd1000000000;
   localparam logic [31:0] MS_PER_SEC     = 32'd1000;
   localparam logic [19:0] US_PER_SEC     = 20'd1000000;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
   // 1 January 1970 was a Thursday
   localparam logic [15:0] EPOCH_WEEKDAY  = 16'd4;

   // reciprocals for constant division, rounded down
   localparam logic [63:0] RECIP_DAY  = (64'd1 << 48) / 64'd86400;
   localparam logic [63:0] RECIP_HOUR = (64'd1 << 40) / 64'd3600;
   localparam logic [63:0] RECIP_MIN  = (64'd1 << 40) / 64'd60;
   localparam logic [63:0] RECIP_WEEK = (64'd1 << 40) / 64'd7;

   typedef enum logic [2:0] {
      OP_ADD        = 3'd0,
      OP_SUB        = 3'd1,
      OP_DIV        = 3'd2,
      OP_ADD_MILLIS = 3'd3,
      OP_ADD_OFFSET = 3'd4,
      OP_FROM_EPOCH = 3'd5
   } opcode_type;

   // request fields carried alongside the divider
   typedef struct packed {
      logic [2:0]           op;
      logic [STAMP_W-1:0]   stamp_a;
      logic [STAMP_W-1:0]   stamp_b;
      logic [WORD_W-1:0]    word;
      logic [WORD_W-1:0]    epoch;
      logic [NANOS_W-1:0]   nanos;
   } side_type;

endpackage

FILE: rtl/nta_front.sv
// Input stage: operand selection for the divider, epoch seconds and nanoseconds.
module nta_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [2:0]                    in_op,
   input  logic [nta_pkg::STAMP_W-1:0]   in_stamp_a,
   input  logic [nta_pkg::STAMP_W-1:0]   in_stamp_b,
   input  logic [nta_pkg::WORD_W-1:0]    in_word,
   input  logic [nta_pkg::NANOS_W-1:0]   in_nanos,
   output logic                          out_valid,
   output nta_pkg::side_type             out_side,
   output logic [nta_pkg::STAMP_W-1:0]   out_num,
   output logic [nta_pkg::WORD_W-1:0]    out_den
);

   logic                          valid_ff;
   nta_pkg::side_type             side_ff, side_in;
   logic [nta_pkg::STAMP_W-1:0]   num_ff, num_in;
   logic [nta_pkg::WORD_W-1:0]    den_ff, den_in;
   logic [61:0]                   nanos_prod;

   // pick dividend and divisor per operation
   always_comb begin
      case (in_op)
         nta_pkg::OP_DIV: begin
            num_in = in_stamp_a;
            den_in = in_word;
         end
         nta_pkg::OP_ADD_MILLIS: begin
            num_in = {in_word, 32'd0} - {32'd0, in_word};
            den_in = nta_pkg::MS_PER_SEC;
         end
         nta_pkg::OP_FROM_EPOCH: begin
            num_in = {2'd0, in_nanos, 32'd0};
            den_in = nta_pkg::NS_PER_SEC;
         end
         default: begin
            num_in = '0;
            den_in = 32'd1;
         end
      endcase
   end

   // fraction to nanoseconds and Unix seconds of stamp_a
   always_comb begin
      nanos_prod      = {30'd0, in_stamp_a[31:0]} * {32'd0, nta_pkg::NS_PER_SEC[29:0]};
      side_in.op      = in_op;
      side_in.stamp_a = in_stamp_a;
      side_in.stamp_b = in_stamp_b;
      side_in.word    = in_word;
      side_in.epoch   = in_stamp_a[63:32] - nta_pkg::NTP_UNIX_DELTA;
      side_in.nanos   = nanos_prod[61:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

FILE: rtl/nta_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64 by 32 bits.
module nta_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  nta_pkg::side_type             in_side,
   input  logic [nta_pkg::STAMP_W-1:0]   in_num,
   input  logic [nta_pkg::WORD_W-1:0]    in_den,
   output logic                          out_valid,
   output nta_pkg::side_type             out_side,
   output logic [nta_pkg::STAMP_W-1:0]   out_quot
);

   localparam int N = nta_pkg::DIV_STAGES;

   logic                          valid_ff [N];
   nta_pkg::side_type             side_ff  [N];
   logic [nta_pkg::STAMP_W-1:0]   word_ff  [N];
   logic [nta_pkg::WORD_W-1:0]    rem_ff   [N];
   logic [nta_pkg::WORD_W-1:0]    den_ff   [N];

   logic [nta_pkg::STAMP_W-1:0]   word_in  [N];
   logic [nta_pkg::WORD_W-1:0]    rem_in   [N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                          prev_valid;
      nta_pkg::side_type             prev_side;
      logic [nta_pkg::STAMP_W-1:0]   prev_word;
      logic [nta_pkg::WORD_W-1:0]    prev_rem;
      logic [nta_pkg::WORD_W-1:0]    prev_den;
      logic [32:0]                   trial;
      logic [32:0]                   diff;
      logic                          fits;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_side  = in_side;
         assign prev_word  = in_num;
         assign prev_rem   = '0;
         assign prev_den   = in_den;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_side  = side_ff[s-1];
         assign prev_word  = word_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_den   = den_ff[s-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial      = {prev_rem, prev_word[nta_pkg::STAMP_W-1]};
         diff       = trial - {1'b0, prev_den};
         fits       = (trial >= {1'b0, prev_den});
         rem_in[s]  = fits ? diff[31:0] : trial[31:0];
         word_in[s] = {prev_word[nta_pkg::STAMP_W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[s] <= prev_side;
         word_ff[s] <= word_in[s];
         rem_ff[s]  <= rem_in[s];
         den_ff[s]  <= prev_den;
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign out_quot  = word_ff[N-1];

endmodule

FILE: rtl/nta_back.sv
// Back stages: result select and calendar breakdown of the epoch seconds.
module nta_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  nta_pkg::side_type             in_side,
   input  logic [nta_pkg::STAMP_W-1:0]   in_quot,
   output logic                          out_valid,
   output logic [nta_pkg::STAMP_W-1:0]   out_stamp,
   output logic                          out_div_error,
   output logic [nta_pkg::WORD_W-1:0]    out_epoch,
   output logic [nta_pkg::NANOS_W-1:0]   out_nanos,
   output logic [nta_pkg::MICROS_W-1:0]  out_micros,
   output logic [2:0]                    out_weekday,
   output logic [4:0]                    out_hours,
   output logic [5:0]                    out_minutes,
   output logic [5:0]                    out_seconds
);

   // valid bits of stages one to six
   logic [5:0] valid_ff;

   // carried payload
   logic [63:0] stamp1_ff, stamp2_ff, stamp3_ff, stamp4_ff, stamp5_ff, stamp6_ff;
   logic        err1_ff, err2_ff, err3_ff, err4_ff, err5_ff, err6_ff;
   logic [31:0] epoch1_ff, epoch2_ff, epoch3_ff, epoch4_ff, epoch5_ff, epoch6_ff;
   logic [29:0] nanos1_ff, nanos2_ff, nanos3_ff, nanos4_ff, nanos5_ff, nanos6_ff;
   logic [31:0] frac1_ff, frac2_ff, frac3_ff, frac4_ff;
   logic [19:0] micros5_ff, micros6_ff;

   // calendar pipeline
   logic [15:0] day_est1_ff;
   logic [15:0] day2_ff;
   logic [16:0] sod2_ff, sod3_ff;
   logic [4:0]  hour_est3_ff;
   logic [15:0] wk_x3_ff;
   logic [12:0] wk_est3_ff;
   logic [4:0]  hours4_ff, hours5_ff, hours6_ff;
   logic [11:0] rem_h4_ff, rem_h5_ff;
   logic [2:0]  weekday4_ff, weekday5_ff, weekday6_ff;
   logic [5:0]  min_est5_ff;
   logic [5:0]  minutes6_ff, seconds6_ff;

   // next values
   logic [63:0] stamp1_in;
   logic        err1_in;
   logic [63:0] day_prod;
   logic [31:0] rem0_full;
   logic [17:0] rem0;
   logic [15:0] day2_in;
   logic [16:0] sod2_in;
   logic [15:0] wk_x3_in;
   logic [45:0] hour_prod;
   logic [53:0] wk_prod;
   logic [16:0] rem_hr;
   logic [11:0] rem_h4_in;
   logic [4:0]  hours4_in;
   logic [15:0] wk_rem_full;
   logic [3:0]  wk_rem;
   logic [2:0]  weekday4_in;
   logic [46:0] min_prod;
   logic [51:0] micros_prod;
   logic [11:0] rem_m_full;
   logic [6:0]  rem_m;
   logic [5:0]  minutes6_in, seconds6_in;

   // stage one: result per opcode and day estimate
   always_comb begin
      err1_in = 1'b0;
      case (in_side.op)
         nta_pkg::OP_ADD:        stamp1_in = in_side.stamp_a + in_side.stamp_b;
         nta_pkg::OP_SUB:        stamp1_in = in_side.stamp_a - in_side.stamp_b;
         nta_pkg::OP_DIV: begin
            err1_in   = (in_side.word == '0);
            stamp1_in = err1_in ? '1 : in_quot;
         end
         nta_pkg::OP_ADD_MILLIS: stamp1_in = in_side.stamp_a + in_quot;
         nta_pkg::OP_ADD_OFFSET: stamp1_in = in_side.stamp_a + in_side.stamp_b;
         nta_pkg::OP_FROM_EPOCH:
            stamp1_in = {in_side.word + nta_pkg::NTP_UNIX_DELTA, in_quot[31:0]};
         default:                stamp1_in = '0;
      endcase
      day_prod = {32'd0, in_side.epoch} * {32'd0, nta_pkg::RECIP_DAY[31:0]};
   end

   // stage two: correct the day, second of day
   always_comb begin
      rem0_full = epoch1_ff - ({16'd0, day_est1_ff} * {15'd0, nta_pkg::SECS_PER_DAY});
      rem0      = rem0_full[17:0];
      if (rem0 >= {1'b0, nta_pkg::SECS_PER_DAY}) begin
         day2_in = day_est1_ff + 16'd1;
         sod2_in = 17'(rem0 - {1'b0, nta_pkg::SECS_PER_DAY});
      end else begin
         day2_in = day_est1_ff;
         sod2_in = rem0[16:0];
      end
   end

   // stage three: hour and week estimates
   always_comb begin
      wk_x3_in  = day2_ff + nta_pkg::EPOCH_WEEKDAY;
      hour_prod = {29'd0, sod2_ff} * {17'd0, nta_pkg::RECIP_HOUR[28:0]};
      wk_prod   = {38'd0, wk_x3_in} * {16'd0, nta_pkg::RECIP_WEEK[37:0]};
   end

   // stage four: correct hours and weekday
   always_comb begin
      rem_hr = sod3_ff - ({12'd0, hour_est3_ff} * {5'd0, nta_pkg::SECS_PER_HOUR});
      if (rem_hr >= {5'd0, nta_pkg::SECS_PER_HOUR}) begin
         hours4_in = hour_est3_ff + 5'd1;
         rem_h4_in = 12'(rem_hr - {5'd0, nta_pkg::SECS_PER_HOUR});
      end else begin
         hours4_in = hour_est3_ff;
         rem_h4_in = rem_hr[11:0];
      end
      wk_rem_full = wk_x3_ff - ({3'd0, wk_est3_ff} * {13'd0, nta_pkg::DAYS_PER_WEEK});
      wk_rem      = wk_rem_full[3:0];
      if (wk_rem >= {1'b0, nta_pkg::DAYS_PER_WEEK}) begin
         weekday4_in = 3'(wk_rem - {1'b0, nta_pkg::DAYS_PER_WEEK});
      end else begin
         weekday4_in = wk_rem[2:0];
      end
   end

   // stage five: minute estimate and microseconds
   always_comb begin
      min_prod    = {35'd0, rem_h4_ff} * {12'd0, nta_pkg::RECIP_MIN[34:0]};
      micros_prod = {20'd0, frac4_ff} * {32'd0, nta_pkg::US_PER_SEC};
   end

   // stage six: correct minutes, second of minute
   always_comb begin
      rem_m_full = rem_h5_ff - ({6'd0, min_est5_ff} * {6'd0, nta_pkg::SECS_PER_MIN});
      rem_m      = rem_m_full[6:0];
      if (rem_m >= {1'b0, nta_pkg::SECS_PER_MIN}) begin
         minutes6_in = min_est5_ff + 6'd1;
         seconds6_in = 6'(rem_m - {1'b0, nta_pkg::SECS_PER_MIN});
      end else begin
         minutes6_in = min_est5_ff;
         seconds6_in = rem_m[5:0];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      stamp1_ff   <= stamp1_in;
      err1_ff     <= err1_in;
      epoch1_ff   <= in_side.epoch;
      nanos1_ff   <= in_side.nanos;
      frac1_ff    <= in_side.stamp_a[31:0];
      day_est1_ff <= day_prod[63:48];

      stamp2_ff   <= stamp1_ff;
      err2_ff     <= err1_ff;
      epoch2_ff   <= epoch1_ff;
      nanos2_ff   <= nanos1_ff;
      frac2_ff    <= frac1_ff;
      day2_ff     <= day2_in;
      sod2_ff     <= sod2_in;

      stamp3_ff    <= stamp2_ff;
      err3_ff      <= err2_ff;
      epoch3_ff    <= epoch2_ff;
      nanos3_ff    <= nanos2_ff;
      frac3_ff     <= frac2_ff;
      sod3_ff      <= sod2_ff;
      hour_est3_ff <= hour_prod[44:40];
      wk_x3_ff     <= wk_x3_in;
      wk_est3_ff   <= wk_prod[52:40];

      stamp4_ff   <= stamp3_ff;
      err4_ff     <= err3_ff;
      epoch4_ff   <= epoch3_ff;
      nanos4_ff   <= nanos3_ff;
      frac4_ff    <= frac3_ff;
      hours4_ff   <= hours4_in;
      rem_h4_ff   <= rem_h4_in;
      weekday4_ff <= weekday4_in;

      stamp5_ff   <= stamp4_ff;
      err5_ff     <= err4_ff;
      epoch5_ff   <= epoch4_ff;
      nanos5_ff   <= nanos4_ff;
      hours5_ff   <= hours4_ff;
      rem_h5_ff   <= rem_h4_ff;
      weekday5_ff <= weekday4_ff;
      min_est5_ff <= min_prod[45:40];
      micros5_ff  <= micros_prod[51:32];

      stamp6_ff   <= stamp5_ff;
      err6_ff     <= err5_ff;
      epoch6_ff   <= epoch5_ff;
      nanos6_ff   <= nanos5_ff;
      micros6_ff  <= micros5_ff;
      hours6_ff   <= hours5_ff;
      weekday6_ff <= weekday5_ff;
      minutes6_ff <= minutes6_in;
      seconds6_ff <= seconds6_in;
   end

   assign out_valid     = valid_ff[5];
   assign out_stamp     = stamp6_ff;
   assign out_div_error = err6_ff;
   assign out_epoch     = epoch6_ff;
   assign out_nanos     = nanos6_ff;
   assign out_micros    = micros6_ff;
   assign out_weekday   = weekday6_ff;
   assign out_hours     = hours6_ff;
   assign out_minutes   = minutes6_ff;
   assign out_seconds   = seconds6_ff;

endmodule

FILE: rtl/ntp_timestamp_arith_unit.sv
// Top level of the NTP timestamp arithmetic unit: front stage, divider, back stages.
//
//   channel   ports                           handshake
//   request   start, busy, req_*              taken when start is high and busy low
//   result    rsp_valid, rsp_*                one-cycle strobe, cannot be held off
//
// A request can enter every cycle while busy is low; its result passes through
// one front stage, 64 divider stages at one quotient bit each, and six back stages.
// Synchronous reset clears every valid bit; busy is high while reset is held
// and in the first cycle after it.
// Nothing stalls: each request moves one stage per cycle until its strobe.
module ntp_timestamp_arith_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_opcode,
   input  logic [nta_pkg::STAMP_W-1:0]    req_stamp_a,
   input  logic [nta_pkg::STAMP_W-1:0]    req_stamp_b,
   input  logic [nta_pkg::WORD_W-1:0]     req_word_value,
   input  logic [nta_pkg::NANOS_W-1:0]    req_nanos_in,
   output logic                           rsp_valid,
   output logic [nta_pkg::STAMP_W-1:0]    rsp_stamp_out,
   output logic                           rsp_div_error,
   output logic [nta_pkg::WORD_W-1:0]     rsp_epoch_secs,
   output logic [nta_pkg::NANOS_W-1:0]    rsp_nanos_out,
   output logic [nta_pkg::MICROS_W-1:0]   rsp_micros_out,
   output logic [2:0]                     rsp_weekday,
   output logic [4:0]                     rsp_hours,
   output logic [5:0]                     rsp_minutes,
   output logic [5:0]                     rsp_second_of_minute
);

   logic                          busy_ff, busy_in;
   logic                          accept;
   logic                          front_valid;
   nta_pkg::side_type             front_side;
   logic [nta_pkg::STAMP_W-1:0]   front_num;
   logic [nta_pkg::WORD_W-1:0]    front_den;
   logic                          div_valid;
   nta_pkg::side_type             div_side;
   logic [nta_pkg::STAMP_W-1:0]   div_quot;

   // hold off requests right after reset
   assign busy_in = reset;
   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end
   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   nta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_op      (req_opcode),
      .in_stamp_a (req_stamp_a),
      .in_stamp_b (req_stamp_b),
      .in_word    (req_word_value),
      .in_nanos   (req_nanos_in),
      .out_valid  (front_valid),
      .out_side   (front_side),
      .out_num    (front_num),
      .out_den    (front_den)
   );

   nta_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_num    (front_num),
      .in_den    (front_den),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quot  (div_quot)
   );

   nta_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid),
      .in_side       (div_side),
      .in_quot       (div_quot),
      .out_valid     (rsp_valid),
      .out_stamp     (rsp_stamp_out),
      .out_div_error (rsp_div_error),
      .out_epoch     (rsp_epoch_secs),
      .out_nanos     (rsp_nanos_out),
      .out_micros    (rsp_micros_out),
      .out_weekday   (rsp_weekday),
      .out_hours     (rsp_hours),
      .out_minutes   (rsp_minutes),
      .out_seconds   (rsp_second_of_minute)
   );

`ifndef SYNTH
   // every result strobe traces back to a request a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, nta_pkg::LATENCY))
      else $error("result without matching request");

   // zero-divisor results are all ones
   a_div_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> (rsp_stamp_out == '1))
      else $error("divide error without all-ones result");

   // calendar fields stay in range
   a_calendar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_hours < 5'd24) && (rsp_minutes < 6'd60) &&
                     (rsp_second_of_minute < 6'd60) && (rsp_weekday < 3'd7)))
      else $error("calendar field out of range");
`endif

endmodule

FILE: sim/ntp_timestamp_arith_unit_tb.sv
// Self-checking testbench for the NTP timestamp arithmetic unit.
`timescale 1ns / 1ps

module ntp_timestamp_arith_unit_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 1250;

   typedef struct {
      logic [63:0] stamp_out;
      logic        div_error;
      logic [31:0] epoch_secs;
      logic [29:0] nanos_out;
      logic [19:0] micros_out;
      logic [2:0]  weekday;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  second_of_minute;
   } stamp_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = '0;
   logic [63:0] req_stamp_a = '0;
   logic [63:0] req_stamp_b = '0;
   logic [31:0] req_word_value = '0;
   logic [29:0] req_nanos_in = '0;
   logic        rsp_valid;
   logic [63:0] rsp_stamp_out;
   logic        rsp_div_error;
   logic [31:0] rsp_epoch_secs;
   logic [29:0] rsp_nanos_out;
   logic [19:0] rsp_micros_out;
   logic [2:0]  rsp_weekday;
   logic [4:0]  rsp_hours;
   logic [5:0]  rsp_minutes;
   logic [5:0]  rsp_second_of_minute;

   int error_count = 0;
   int idle_cycles = 0;

   ntp_timestamp_arith_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_stamp_a(req_stamp_a), .req_stamp_b(req_stamp_b),
      .req_word_value(req_word_value), .req_nanos_in(req_nanos_in),
      .rsp_valid(rsp_valid), .rsp_stamp_out(rsp_stamp_out),
      .rsp_div_error(rsp_div_error), .rsp_epoch_secs(rsp_epoch_secs),
      .rsp_nanos_out(rsp_nanos_out), .rsp_micros_out(rsp_micros_out),
      .rsp_weekday(rsp_weekday), .rsp_hours(rsp_hours), .rsp_minutes(rsp_minutes),
      .rsp_second_of_minute(rsp_second_of_minute)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // compute the expected result of one request
   function automatic stamp_result_type compute_stamp(logic [2:0] op, logic [63:0] a,
         logic [63:0] b, logic [31:0] w, logic [29:0] ns);
      stamp_result_type r;
      logic [127:0]  wide;
      logic [31:0]   ep;
      r.div_error = 1'b0;
      case (op)
         nta_pkg::OP_ADD, nta_pkg::OP_ADD_OFFSET: r.stamp_out = a + b;
         nta_pkg::OP_SUB: r.stamp_out = a - b;
         nta_pkg::OP_DIV: begin
            if (w == 0) begin
               r.stamp_out = '1;
               r.div_error = 1'b1;
            end else begin
               r.stamp_out = a / {32'd0, w};
            end
         end
         nta_pkg::OP_ADD_MILLIS: begin
            wide = {96'd0, w} * 128'hFFFFFFFF;
            r.stamp_out = a + 64'(wide / 128'd1000);
         end
         nta_pkg::OP_FROM_EPOCH: begin
            wide = ({98'd0, ns} << 32) / 128'd1000000000;
            r.stamp_out = {w + nta_pkg::NTP_UNIX_DELTA, wide[31:0]};
         end
         default: r.stamp_out = '0;
      endcase
      ep = a[63:32] - nta_pkg::NTP_UNIX_DELTA;
      r.epoch_secs = ep;
      wide = {96'd0, a[31:0]} * 128'd1000000000;
      r.nanos_out = wide[61:32];
      wide = {96'd0, a[31:0]} * 128'd1000000;
      r.micros_out = wide[51:32];
      r.weekday = 3'((ep / 32'd86400 + 32'd4) % 32'd7);
      r.hours = 5'((ep % 32'd86400) / 32'd3600);
      r.minutes = 6'((ep % 32'd3600) / 32'd60);
      r.second_of_minute = 6'(ep % 32'd60);
      return r;
   endfunction

   class stamp_scoreboard;
      stamp_result_type pending[$];

      function void note_request(logic [2:0] op, logic [63:0] a, logic [63:0] b,
                                 logic [31:0] w, logic [29:0] ns);
         pending.push_back(compute_stamp(op, a, b, w, ns));
      endfunction

      task check_result(stamp_result_type got);
         stamp_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected", got.stamp_out, 64'd0);
         end else begin
            want = pending.pop_front();
            if (got.stamp_out !== want.stamp_out)
               report_mismatch("stamp_out", got.stamp_out, want.stamp_out);
            if (got.div_error !== want.div_error)
               report_mismatch("div_error", 64'(got.div_error), 64'(want.div_error));
            if (got.epoch_secs !== want.epoch_secs)
               report_mismatch("epoch_secs", 64'(got.epoch_secs), 64'(want.epoch_secs));
            if (got.nanos_out !== want.nanos_out)
               report_mismatch("nanos_out", 64'(got.nanos_out), 64'(want.nanos_out));
            if (got.micros_out !== want.micros_out)
               report_mismatch("micros_out", 64'(got.micros_out), 64'(want.micros_out));
            if (got.weekday !== want.weekday)
               report_mismatch("weekday", 64'(got.weekday), 64'(want.weekday));
            if (got.hours !== want.hours)
               report_mismatch("hours", 64'(got.hours), 64'(want.hours));
            if (got.minutes !== want.minutes)
               report_mismatch("minutes", 64'(got.minutes), 64'(want.minutes));
            if (got.second_of_minute !== want.second_of_minute)
               report_mismatch("second_of_minute", 64'(got.second_of_minute),
                               64'(want.second_of_minute));
         end
      endtask
   endclass

   stamp_scoreboard sb = new();

   // sample results and accepted requests at each edge
   always @(posedge clock) begin
      stamp_result_type got;
      logic             moved;
      moved = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            sb.note_request(req_opcode, req_stamp_a, req_stamp_b, req_word_value,
                            req_nanos_in);
            moved = 1'b1;
         end
         if (rsp_valid) begin
            got.stamp_out = rsp_stamp_out;
            got.div_error = rsp_div_error;
            got.epoch_secs = rsp_epoch_secs;
            got.nanos_out = rsp_nanos_out;
            got.micros_out = rsp_micros_out;
            got.weekday = rsp_weekday;
            got.hours = rsp_hours;
            got.minutes = rsp_minutes;
            got.second_of_minute = rsp_second_of_minute;
            sb.check_result(got);
            moved = 1'b1;
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ntp_timestamp_arith_unit_tb: errors");
         $finish;
      end
   end

   // present one request and hold it until taken
   task automatic send_request(logic [2:0] op, logic [63:0] a, logic [63:0] b,
                               logic [31:0] w, logic [29:0] ns);
      start <= 1'b1;
      req_opcode <= op;
      req_stamp_a <= a;
      req_stamp_b <= b;
      req_word_value <= w;
      req_nanos_in <= ns;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // pick operands that stress edges now and then
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return $urandom_range(1, 16);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [2:0]  op;
      logic [63:0] a;
      int          burst;
      int          sent;
      int          gap;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every opcode, special cases
      send_request(nta_pkg::OP_ADD, '1, 64'd1, 0, 0);
      send_request(nta_pkg::OP_ADD, '0, '0, 0, 0);
      send_request(nta_pkg::OP_SUB, '0, 64'd1, 0, 0);
      send_request(nta_pkg::OP_SUB, '1, '1, '1, '1);
      send_request(nta_pkg::OP_DIV, '1, 0, 32'd0, 0);
      send_request(nta_pkg::OP_DIV, '1, 0, 32'd1, 0);
      send_request(nta_pkg::OP_DIV, '1, 0, '1, 0);
      send_request(nta_pkg::OP_DIV, 64'd5, 0, 32'd7, 0);
      send_request(nta_pkg::OP_ADD_MILLIS, '1, 0, '1, 0);
      send_request(nta_pkg::OP_ADD_MILLIS, 0, 0, 32'd1000, 0);
      send_request(nta_pkg::OP_ADD_OFFSET, 64'h0000_0001_0000_0000, '1, 0, 0);
      send_request(nta_pkg::OP_ADD_OFFSET, 0, 64'h8000_0000_0000_0000, 0, 0);
      send_request(nta_pkg::OP_FROM_EPOCH, 0, 0, 32'd0, 30'd0);
      send_request(nta_pkg::OP_FROM_EPOCH, 0, 0, '1, 30'd999999999);
      send_request(nta_pkg::OP_FROM_EPOCH, 0, 0, 32'd12345, 30'd1000000000);
      send_request(nta_pkg::OP_FROM_EPOCH, 0, 0, 32'd1, '1);
      send_request(3'd6, '1, '1, '1, '1);
      send_request(3'd7, {nta_pkg::NTP_UNIX_DELTA, 32'hFFFFFFFF}, 0, 0, 0);
      send_request(nta_pkg::OP_ADD, {nta_pkg::NTP_UNIX_DELTA - 32'd1, 32'd0}, 0, 0, 0);
      send_request(nta_pkg::OP_ADD,
                   {nta_pkg::NTP_UNIX_DELTA + 32'd86399, 32'h8000_0000}, 0, 0, 0);
      pause_sender(3);

      // random requests in bursts with gaps
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(1, 8);
         repeat (burst) begin
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            a = rand64();
            if ($urandom_range(0, 3) == 0)
               a[63:32] = nta_pkg::NTP_UNIX_DELTA + $urandom_range(0, 200000);
            send_request(op, a, rand64(), pick_word(), 30'($urandom()));
            sent++;
         end
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap > 0)
            pause_sender(gap);
      end
      start <= 1'b0;

      // drain the pipeline
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (nta_pkg::LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("ntp_timestamp_arith_unit_tb: clean");
      end else begin
         $display("ntp_timestamp_arith_unit_tb: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/nta_pkg.sv
rtl/nta_front.sv
rtl/nta_div.sv
rtl/nta_back.sv
rtl/ntp_timestamp_arith_unit.sv
sim/ntp_timestamp_arith_unit_tb.sv
